// ===== rtl/core/qau_pkg.sv =====
// Shared types, opcodes and per-stage step functions for the quaternion unit.
package qau_pkg;

	localparam int DW         = 32;
	localparam int FB         = 16;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 33;

	localparam logic [31:0] SMAX = 32'h7fff_ffff;
	localparam logic [31:0] SMIN = 32'h8000_0000;
	localparam logic [31:0] ONE  = 32'h0001_0000;

	typedef enum logic [3:0] {
		FN_ADD   = 4'd0,
		FN_SUB   = 4'd1,
		FN_MUL   = 4'd2,
		FN_SCALE = 4'd3,
		FN_CONJ  = 4'd4,
		FN_DOT   = 4'd5,
		FN_INV   = 4'd6,
		FN_NORM  = 4'd7,
		FN_ROT   = 4'd8,
		FN_LEN   = 4'd9
	} func_t;

	typedef struct packed {
		logic [31:0] v;
		logic        c;
	} sat_t;

	// square root stage record
	typedef struct packed {
		logic [3:0]       func;
		logic [3:0][31:0] a;
		logic [3:0][31:0] rq;
		logic [31:0]      rsc;
		logic             clip;
		logic [64:0]      ssum;
		logic [63:0]      rem;
		logic [63:0]      root;
	} rt_t;

	// divide stage record
	typedef struct packed {
		logic [3:0]       func;
		logic [3:0][31:0] rq;
		logic [31:0]      rsc;
		logic             clip;
		logic             degen;
		logic             use_div;
		logic [3:0]       neg;
		logic [3:0][63:0] num;
		logic [63:0]      den;
		logic [3:0][64:0] rem;
		logic [3:0][32:0] quo;
	} dv_t;

	function automatic sat_t sat66(input logic signed [65:0] x);
		sat_t o;
		if (x > 66'sd2147483647) begin
			o.v = SMAX;
			o.c = 1'b1;
		end else if (x < -66'sd2147483648) begin
			o.v = SMIN;
			o.c = 1'b1;
		end else begin
			o.v = x[31:0];
			o.c = 1'b0;
		end
		return o;
	endfunction

	function automatic logic signed [65:0] ext64(input logic [63:0] p);
		return $signed({{2{p[63]}}, p});
	endfunction

	function automatic logic signed [65:0] ext32(input logic [31:0] p);
		return $signed({{34{p[31]}}, p});
	endfunction

	// exact sum of four products, floor shift, saturate; ng negates a term
	function automatic sat_t fsum4(input logic [63:0] p0, input logic [63:0] p1,
			input logic [63:0] p2, input logic [63:0] p3, input logic [3:0] ng);
		logic signed [65:0] t0, t1, t2, t3, acc;
		t0  = ng[0] ? -ext64(p0) : ext64(p0);
		t1  = ng[1] ? -ext64(p1) : ext64(p1);
		t2  = ng[2] ? -ext64(p2) : ext64(p2);
		t3  = ng[3] ? -ext64(p3) : ext64(p3);
		acc = t0 + t1 + t2 + t3;
		return sat66(acc >>> FB);
	endfunction

	// one bit pair of the integer square root
	function automatic rt_t rt_step(input rt_t x, input int k);
		rt_t o;
		logic [63:0] bval, trial;
		o     = x;
		bval  = 64'd1 << (62 - 2 * k);
		trial = x.root + bval;
		if (x.rem >= trial) begin
			o.rem  = x.rem - trial;
			o.root = (x.root >> 1) + bval;
		end else begin
			o.root = x.root >> 1;
		end
		return o;
	endfunction

	// length handling, degenerate cases and divider setup
	function automatic dv_t dv_entry(input rt_t x);
		dv_t o;
		logic carry, zero;
		logic [32:0] len;
		logic [31:0] mag;
		sat_t ls;
		o       = '0;
		o.func  = x.func;
		o.rq    = x.rq;
		o.rsc   = x.rsc;
		o.clip  = x.clip;
		carry   = x.ssum[64];
		zero    = (x.ssum == 65'd0);
		len     = carry ? {1'b1, 32'd0} : {1'b0, x.root[31:0]};
		case (x.func)
			FN_LEN: begin
				ls     = sat66($signed({33'd0, len}));
				o.rsc  = ls.v;
				o.clip = ls.c;
			end
			FN_INV: begin
				if (carry) begin
					o.rq = '0;
				end else if (zero) begin
					o.rq[3] = ONE;
					o.degen = 1'b1;
				end else begin
					o.use_div = 1'b1;
					o.den     = x.ssum[63:0];
					for (int i = 0; i < 4; i++) begin
						mag      = x.a[i][31] ? (32'd0 - x.a[i]) : x.a[i];
						o.num[i] = {mag, 32'd0};
						o.neg[i] = (i < 3) ? (!x.a[i][31] && (x.a[i] != 32'd0))
							: x.a[i][31];
					end
				end
			end
			FN_NORM: begin
				if (zero) begin
					o.rq[3] = ONE;
					o.degen = 1'b1;
				end else begin
					o.use_div = 1'b1;
					o.den     = {31'd0, len};
					for (int i = 0; i < 4; i++) begin
						mag      = x.a[i][31] ? (32'd0 - x.a[i]) : x.a[i];
						o.num[i] = {16'd0, mag, 16'd0};
						o.neg[i] = x.a[i][31];
					end
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < 4; i++)
			o.rem[i] = {34'd0, o.num[i][63:33]};
		return o;
	endfunction

	// one restoring quotient bit on all four lanes
	function automatic dv_t dv_step(input dv_t x, input int k);
		dv_t o;
		logic [5:0]  j;
		logic [64:0] r2;
		o = x;
		j = 6'(DIV_STEPS - 1 - k);
		for (int i = 0; i < 4; i++) begin
			r2 = {x.rem[i][63:0], x.num[i][j]};
			if (r2 >= {1'b0, x.den}) begin
				o.rem[i]    = r2 - {1'b0, x.den};
				o.quo[i][j] = 1'b1;
			end else begin
				o.rem[i] = r2;
			end
		end
		return o;
	endfunction

endpackage

// ===== rtl/core/quaternion_arithmetic_unit_core.sv =====
// Quaternion arithmetic unit: fully pipelined Q16.16 quaternion ALU.
//
//  channel | signals                                   | dir | transaction
//  --------+-------------------------------------------+-----+--------------------------
//  in      | in_valid, in_ready, func, a_*, b_*, scale | in  | one operation request
//  out     | out_valid, out_ready, r_*, degenerate,    | out | one result
//          | saturated                                 |     |
//
// One transaction enters every cycle while the pipe advances (4 front stages,
// 33 square root stages, 34 divide stages, result register). Depth is set by
// the 32 bit-pair steps of the square root and the 33 quotient bits of the
// divider, one per stage. All stages advance together whenever the result
// register is empty or being taken, so a stall freezes the whole pipe and
// nothing is lost or repeated. arst_n clears only the valid bits.
module quaternion_arithmetic_unit_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         func,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] a_w,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] b_w,
	input  logic signed [31:0] scale_factor,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] r_x,
	output logic signed [31:0] r_y,
	output logic signed [31:0] r_z,
	output logic signed [31:0] r_w,
	output logic signed [31:0] r_scalar,
	output logic               degenerate,
	output logic               saturated
);

	logic adv;

	// stage 1: registered inputs
	logic               vld_s1;
	logic [3:0]         func_s1;
	logic signed [31:0] a_s1 [4];
	logic signed [31:0] b_s1 [4];
	logic signed [31:0] sf_s1;

	// stage 2: products and elementwise ops
	logic               vld_s2;
	logic [3:0]         func_s2;
	logic [31:0]        a_s2 [4];
	logic signed [63:0] prod_s2 [4][4];
	logic signed [63:0] scp_s2 [4];
	logic signed [63:0] sqp_s2 [4];
	logic [31:0]        smp_s2 [4];
	logic               smpc_s2;

	// stage 3: sums, first Hamilton product
	logic               vld_s3;
	logic [3:0]         func_s3;
	logic signed [31:0] a_s3 [4];
	logic signed [31:0] rq_s3 [4];
	logic [31:0]        rsc_s3;
	logic               clip_s3;
	logic [64:0]        ssum_s3;

	// stage 4: second rotate product
	logic               vld_s4;
	logic [3:0]         func_s4;
	logic [31:0]        a_s4 [4];
	logic [31:0]        rq_s4 [4];
	logic [31:0]        rsc_s4;
	logic               clip_s4;
	logic [64:0]        ssum_s4;
	logic signed [63:0] up_s4 [4][4];

	// square root and divide tails
	qau_pkg::rt_t rt_s [qau_pkg::SQRT_STEPS+1];
	logic         rt_vld_s [qau_pkg::SQRT_STEPS+1];
	qau_pkg::dv_t dv_s [qau_pkg::DIV_STEPS+1];
	logic         dv_vld_s [qau_pkg::DIV_STEPS+1];

	// next-value logic
	logic [31:0]      smp_n [4];
	logic             smpc_n;
	qau_pkg::sat_t    st_tmp;
	qau_pkg::sat_t    ham [4];
	qau_pkg::sat_t    scl [4];
	qau_pkg::sat_t    dotr;
	logic [31:0]      rq3_n [4];
	logic [31:0]      rsc3_n;
	logic             clip3_n;
	logic [64:0]      ssum_n;
	qau_pkg::rt_t     rt_in;
	qau_pkg::sat_t    rot [3];
	logic [3:0][31:0] fin_rq;
	logic             fin_clip;

	// whole pipe moves when the result slot is free
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_valid <= 1'b0;
			for (int k = 0; k <= qau_pkg::SQRT_STEPS; k++)
				rt_vld_s[k] <= 1'b0;
			for (int k = 0; k <= qau_pkg::DIV_STEPS; k++)
				dv_vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			rt_vld_s[0] <= vld_s4;
			for (int k = 1; k <= qau_pkg::SQRT_STEPS; k++)
				rt_vld_s[k] <= rt_vld_s[k-1];
			dv_vld_s[0] <= rt_vld_s[qau_pkg::SQRT_STEPS];
			for (int k = 1; k <= qau_pkg::DIV_STEPS; k++)
				dv_vld_s[k] <= dv_vld_s[k-1];
			out_valid   <= dv_vld_s[qau_pkg::DIV_STEPS];
		end
	end

	// stage 2 elementwise results: add, sub, conjugate
	always_comb begin
		smpc_n = 1'b0;
		for (int i = 0; i < 4; i++) begin
			case (func_s1)
				qau_pkg::FN_ADD:
					st_tmp = qau_pkg::sat66(qau_pkg::ext32(a_s1[i]) + qau_pkg::ext32(b_s1[i]));
				qau_pkg::FN_SUB:
					st_tmp = qau_pkg::sat66(qau_pkg::ext32(a_s1[i]) - qau_pkg::ext32(b_s1[i]));
				qau_pkg::FN_CONJ:
					st_tmp = (i < 3) ? qau_pkg::sat66(-qau_pkg::ext32(a_s1[i]))
						: qau_pkg::sat66(qau_pkg::ext32(a_s1[i]));
				default:
					st_tmp = '0;
			endcase
			smp_n[i] = st_tmp.v;
			smpc_n   = smpc_n | st_tmp.c;
		end
	end

	// stage 3: Hamilton product, dot, scale, squared length
	always_comb begin
		ham[0] = qau_pkg::fsum4(prod_s2[3][0], prod_s2[0][3], prod_s2[1][2], prod_s2[2][1],
			4'b1000);
		ham[1] = qau_pkg::fsum4(prod_s2[3][1], prod_s2[0][2], prod_s2[1][3], prod_s2[2][0],
			4'b0010);
		ham[2] = qau_pkg::fsum4(prod_s2[3][2], prod_s2[0][1], prod_s2[1][0], prod_s2[2][3],
			4'b0100);
		ham[3] = qau_pkg::fsum4(prod_s2[3][3], prod_s2[0][0], prod_s2[1][1], prod_s2[2][2],
			4'b1110);
		dotr   = qau_pkg::fsum4(prod_s2[0][0], prod_s2[1][1], prod_s2[2][2], prod_s2[3][3],
			4'b0000);
		for (int i = 0; i < 4; i++)
			scl[i] = qau_pkg::sat66(qau_pkg::ext64(scp_s2[i]) >>> qau_pkg::FB);
		ssum_n = 65'(sqp_s2[0]) + 65'(sqp_s2[1]) + 65'(sqp_s2[2]) + 65'(sqp_s2[3]);
		rsc3_n  = '0;
		clip3_n = 1'b0;
		for (int i = 0; i < 4; i++)
			rq3_n[i] = '0;
		case (func_s2)
			qau_pkg::FN_ADD, qau_pkg::FN_SUB, qau_pkg::FN_CONJ: begin
				for (int i = 0; i < 4; i++)
					rq3_n[i] = smp_s2[i];
				clip3_n = smpc_s2;
			end
			qau_pkg::FN_MUL, qau_pkg::FN_ROT: begin
				for (int i = 0; i < 4; i++)
					rq3_n[i] = ham[i].v;
				clip3_n = ham[0].c | ham[1].c | ham[2].c | ham[3].c;
			end
			qau_pkg::FN_SCALE: begin
				for (int i = 0; i < 4; i++)
					rq3_n[i] = scl[i].v;
				clip3_n = scl[0].c | scl[1].c | scl[2].c | scl[3].c;
			end
			qau_pkg::FN_DOT: begin
				rsc3_n  = dotr.v;
				clip3_n = dotr.c;
			end
			default: begin
			end
		endcase
	end

	// stage 5: rotate finish u*conj(a), then square root setup
	always_comb begin
		rot[0] = qau_pkg::fsum4(up_s4[3][0], up_s4[0][3], up_s4[1][2], up_s4[2][1], 4'b0101);
		rot[1] = qau_pkg::fsum4(up_s4[3][1], up_s4[0][2], up_s4[1][3], up_s4[2][0], 4'b1001);
		rot[2] = qau_pkg::fsum4(up_s4[3][2], up_s4[0][1], up_s4[1][0], up_s4[2][3], 4'b0011);
		rt_in.func = func_s4;
		rt_in.rsc  = rsc_s4;
		rt_in.clip = clip_s4;
		rt_in.ssum = ssum_s4;
		rt_in.rem  = ssum_s4[63:0];
		rt_in.root = '0;
		for (int i = 0; i < 4; i++) begin
			rt_in.a[i]  = a_s4[i];
			rt_in.rq[i] = rq_s4[i];
		end
		if (func_s4 == qau_pkg::FN_ROT) begin
			for (int i = 0; i < 3; i++)
				rt_in.rq[i] = rot[i].v;
			rt_in.rq[3] = '0;
			rt_in.clip  = clip_s4 | rot[0].c | rot[1].c | rot[2].c;
		end
	end

	// result: sign and clamp the quotients
	always_comb begin
		fin_rq   = dv_s[qau_pkg::DIV_STEPS].rq;
		fin_clip = dv_s[qau_pkg::DIV_STEPS].clip;
		if (dv_s[qau_pkg::DIV_STEPS].use_div) begin
			for (int i = 0; i < 4; i++) begin
				if (dv_s[qau_pkg::DIV_STEPS].neg[i]) begin
					if (dv_s[qau_pkg::DIV_STEPS].quo[i] > 33'h0_8000_0000) begin
						fin_rq[i] = qau_pkg::SMIN;
						fin_clip  = 1'b1;
					end else begin
						fin_rq[i] = 32'd0 - dv_s[qau_pkg::DIV_STEPS].quo[i][31:0];
					end
				end else begin
					if (dv_s[qau_pkg::DIV_STEPS].quo[i] > 33'h0_7fff_ffff) begin
						fin_rq[i] = qau_pkg::SMAX;
						fin_clip  = 1'b1;
					end else begin
						fin_rq[i] = dv_s[qau_pkg::DIV_STEPS].quo[i][31:0];
					end
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= func;
			a_s1[0] <= a_x;
			a_s1[1] <= a_y;
			a_s1[2] <= a_z;
			a_s1[3] <= a_w;
			b_s1[0] <= b_x;
			b_s1[1] <= b_y;
			b_s1[2] <= b_z;
			// rotate treats b as a pure vector
			b_s1[3] <= (func == qau_pkg::FN_ROT) ? 32'sd0 : b_w;
			sf_s1   <= scale_factor;

			func_s2 <= func_s1;
			smpc_s2 <= smpc_n;
			for (int i = 0; i < 4; i++) begin
				a_s2[i]   <= a_s1[i];
				smp_s2[i] <= smp_n[i];
				scp_s2[i] <= a_s1[i] * sf_s1;
				sqp_s2[i] <= a_s1[i] * a_s1[i];
				for (int j = 0; j < 4; j++)
					prod_s2[i][j] <= a_s1[i] * b_s1[j];
			end

			func_s3 <= func_s2;
			rsc_s3  <= rsc3_n;
			clip_s3 <= clip3_n;
			ssum_s3 <= ssum_n;
			for (int i = 0; i < 4; i++) begin
				a_s3[i]  <= a_s2[i];
				rq_s3[i] <= rq3_n[i];
			end

			func_s4 <= func_s3;
			rsc_s4  <= rsc_s3;
			clip_s4 <= clip_s3;
			ssum_s4 <= ssum_s3;
			for (int i = 0; i < 4; i++) begin
				a_s4[i]  <= a_s3[i];
				rq_s4[i] <= rq_s3[i];
				for (int j = 0; j < 4; j++)
					up_s4[i][j] <= rq_s3[i] * a_s3[j];
			end

			rt_s[0] <= rt_in;
			for (int k = 1; k <= qau_pkg::SQRT_STEPS; k++)
				rt_s[k] <= qau_pkg::rt_step(rt_s[k-1], k - 1);

			dv_s[0] <= qau_pkg::dv_entry(rt_s[qau_pkg::SQRT_STEPS]);
			for (int k = 1; k <= qau_pkg::DIV_STEPS; k++)
				dv_s[k] <= qau_pkg::dv_step(dv_s[k-1], k - 1);

			r_x        <= fin_rq[0];
			r_y        <= fin_rq[1];
			r_z        <= fin_rq[2];
			r_w        <= fin_rq[3];
			r_scalar   <= dv_s[qau_pkg::DIV_STEPS].rsc;
			degenerate <= dv_s[qau_pkg::DIV_STEPS].degen;
			saturated  <= fin_clip;
		end
	end

endmodule
